### rtl/voi_pkg.sv
// ---------------------------------------------------------------------------
// voi_pkg
// Shared constants, types and codes of the voxel occupancy inflation block.
// ---------------------------------------------------------------------------
package voi_pkg;

  localparam int GRID_X      = 256;
  localparam int GRID_Y      = 256;
  localparam int GRID_Z      = 32;
  localparam int MAX_INFLATE = 7;
  localparam int FRAC_BITS   = 8;

  localparam int POS_W  = 24;
  localparam int RNG_W  = 16;
  localparam int STEP_W = 3;
  localparam int RD_XW  = 8;
  localparam int RD_YW  = 8;
  localparam int RD_ZW  = 5;
  localparam int OUT_XW = 8;
  localparam int OUT_YW = 8;
  localparam int OUT_ZW = 5;
  localparam int CFG_IDX_W = 2;

  localparam int XW     = $clog2(GRID_X);
  localparam int YW     = $clog2(GRID_Y);
  localparam int ZW     = $clog2(GRID_Z);
  localparam int ADDR_W = XW + YW;
  localparam int IDX_W  = POS_W - FRAC_BITS;
  localparam int BOX_W  = IDX_W + 2;

  localparam logic [1:0] OP_ODOM  = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_X, CFG_RANGE_Y, CFG_RANGE_Z, CFG_INFLATE
  } cfg_reg_t;

  typedef enum logic [1:0] {CMD_ODOM, CMD_POINT, CMD_READ} cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic                     first;
    logic                     last;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [POS_W-1:0]  pz;
    logic [RD_XW-1:0]         rx;
    logic [RD_YW-1:0]         ry;
    logic [RD_ZW-1:0]         rz;
    logic                     rd_in_map;
  } cmd_t;

  typedef struct packed {
    logic [RNG_W-1:0]  range_x;
    logic [RNG_W-1:0]  range_y;
    logic [RNG_W-1:0]  range_z;
    logic [STEP_W-1:0] inflate;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic              occupied;
    logic              no_odom;
    logic [OUT_XW-1:0] box_min_x;
    logic [OUT_YW-1:0] box_min_y;
    logic [OUT_ZW-1:0] box_min_z;
    logic [OUT_XW-1:0] box_max_x;
    logic [OUT_YW-1:0] box_max_y;
    logic [OUT_ZW-1:0] box_max_z;
  } res_t;

  typedef struct packed {
    logic init_busy;
    logic pop;
  } back_stat_t;

endpackage

### rtl/voi_if.sv
// ---------------------------------------------------------------------------
// voi_if
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface voi_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        op;
  logic                              first_point;
  logic                              last_point;
  logic signed [voi_pkg::POS_W-1:0]  pos_x;
  logic signed [voi_pkg::POS_W-1:0]  pos_y;
  logic signed [voi_pkg::POS_W-1:0]  pos_z;
  logic [voi_pkg::RD_XW-1:0]         read_x;
  logic [voi_pkg::RD_YW-1:0]         read_y;
  logic [voi_pkg::RD_ZW-1:0]         read_z;
  modport source (output valid, op, first_point, last_point, pos_x, pos_y, pos_z,
                  read_x, read_y, read_z, input ready);
  modport sink (input valid, op, first_point, last_point, pos_x, pos_y, pos_z,
                read_x, read_y, read_z, output ready);
endinterface

interface voi_out_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic                       occupied;
  logic                       no_odom;
  logic [voi_pkg::OUT_XW-1:0] box_min_x;
  logic [voi_pkg::OUT_YW-1:0] box_min_y;
  logic [voi_pkg::OUT_ZW-1:0] box_min_z;
  logic [voi_pkg::OUT_XW-1:0] box_max_x;
  logic [voi_pkg::OUT_YW-1:0] box_max_y;
  logic [voi_pkg::OUT_ZW-1:0] box_max_z;
  modport source (output valid, kind, occupied, no_odom, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, input ready);
  modport sink (input valid, kind, occupied, no_odom, box_min_x, box_min_y, box_min_z,
                box_max_x, box_max_y, box_max_z, output ready);
endinterface

### rtl/voi_front.sv
// ---------------------------------------------------------------------------
// voi_front
// Accepts input beats, decodes the op and drops unused codes.
// ---------------------------------------------------------------------------
module voi_front (
  voi_in_if.sink          in_ch,
  input  logic            init_busy,
  input  logic            q_full,
  output logic            push,
  output voi_pkg::cmd_t   cmd
);
  import voi_pkg::*;

  logic accept;

  assign in_ch.ready = !q_full && !init_busy;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    cmd.first     = in_ch.first_point;
    cmd.last      = in_ch.last_point;
    cmd.px        = in_ch.pos_x;
    cmd.py        = in_ch.pos_y;
    cmd.pz        = in_ch.pos_z;
    cmd.rx        = in_ch.read_x;
    cmd.ry        = in_ch.read_y;
    cmd.rz        = in_ch.read_z;
    cmd.rd_in_map = (int'(in_ch.read_x) < GRID_X) && (int'(in_ch.read_y) < GRID_Y) &&
                    (int'(in_ch.read_z) < GRID_Z);
    cmd.kind      = CMD_ODOM;
    push          = 1'b0;
    unique case (in_ch.op)
      OP_ODOM: begin
        cmd.kind = CMD_ODOM;
        push     = accept;
      end
      OP_POINT: begin
        cmd.kind = CMD_POINT;
        push     = accept;
      end
      OP_READ: begin
        cmd.kind = CMD_READ;
        push     = accept;
      end
      default: push = 1'b0;
    endcase
  end

endmodule

### rtl/voi_queue.sv
// ---------------------------------------------------------------------------
// voi_queue
// Two-entry command queue between front and back.
// ---------------------------------------------------------------------------
module voi_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  voi_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output voi_pkg::cmd_t dout,
  output logic          empty
);
  import voi_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/voi_back.sv
// ---------------------------------------------------------------------------
// voi_back
// Executes commands on the column-organized occupancy memory, keeps camera
// and bounding box state, and holds the result register.
// ---------------------------------------------------------------------------
module voi_back (
  input  logic               clk,
  input  logic               rst_n,
  input  voi_pkg::cfg_t      cfg,
  input  voi_pkg::cmd_t      cmd,
  input  logic               q_empty,
  output voi_pkg::back_stat_t stat,
  voi_out_if.source          out_ch
);
  import voi_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_RD_WAIT, ST_RD_OUT, ST_NOODOM, ST_CLR_SET, ST_MCHK,
    ST_MSET, ST_COL_RD, ST_COL_WR, ST_FIN
  } state_t;

  state_t                  state_r;
  cmd_t                    cmd_r;
  logic signed [POS_W-1:0] cam_x_r, cam_y_r, cam_z_r;
  logic                    odom_r, active_r;
  logic signed [BOX_W-1:0] blo_x_r, blo_y_r, blo_z_r, bhi_x_r, bhi_y_r, bhi_z_r;
  logic signed [BOX_W-1:0] c_x_r, c_y_r, c_z_r;
  logic [XW-1:0]           x_r, xe_r;
  logic [YW-1:0]           y_r, ys_r, ye_r;
  logic [GRID_Z-1:0]       mask_r;
  logic                    set_r;
  logic [ADDR_W-1:0]       init_addr_r;
  res_t                    res_r;
  res_t                    res_nxt;
  logic                    res_set;
  logic                    out_valid_r;

  logic [GRID_Z-1:0]       mem [2**ADDR_W];
  logic [GRID_Z-1:0]       rdata_r;
  logic                    mem_we, mem_re;
  logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
  logic [GRID_Z-1:0]       mem_wdata;

  logic                    slot_free, pop;

  function automatic logic signed [BOX_W-1:0] clamp_box(
    input logic signed [BOX_W-1:0] v, input logic signed [BOX_W-1:0] top);
    logic signed [BOX_W-1:0] r;
    r = v;
    if (v < 0) r = '0;
    else if (v > top) r = top;
    return r;
  endfunction

  function automatic logic signed [BOX_W-1:0] pos_idx(input logic signed [POS_W:0] p);
    return BOX_W'(p >>> FRAC_BITS);
  endfunction

  localparam logic signed [BOX_W-1:0] TOP_X = BOX_W'(GRID_X - 1);
  localparam logic signed [BOX_W-1:0] TOP_Y = BOX_W'(GRID_Y - 1);
  localparam logic signed [BOX_W-1:0] TOP_Z = BOX_W'(GRID_Z - 1);

  // clear window
  logic signed [POS_W:0]   cl_lo_x, cl_lo_y, cl_lo_z, cl_hi_x, cl_hi_y, cl_hi_z;
  logic signed [BOX_W-1:0] k_lo_x, k_lo_y, k_lo_z, k_hi_x, k_hi_y, k_hi_z;
  // range check
  logic signed [POS_W:0]   d_x, d_y, d_z;
  logic [POS_W:0]          a_x, a_y, a_z;
  logic                    in_rng;
  // mark window
  logic [STEP_W-1:0]       s_eff;
  logic signed [BOX_W-1:0] s_box, m_lo_x, m_hi_x, m_lo_y, m_hi_y, m_lo_z, m_hi_z;
  logic                    m_empty;
  logic [GRID_Z-1:0]       clr_mask, mrk_mask;
  // final box
  logic signed [BOX_W-1:0] cv_x, cv_y, cv_z, f_lo_x, f_lo_y, f_lo_z, f_hi_x, f_hi_y, f_hi_z;
  logic                    col_last;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign pop       = (state_r == ST_IDLE) && !q_empty;
  assign stat.pop       = pop;
  assign stat.init_busy = (state_r == ST_INIT);

  always_comb begin
    cl_lo_x = $signed({cam_x_r[POS_W-1], cam_x_r}) - $signed((POS_W+1)'(cfg.range_x));
    cl_lo_y = $signed({cam_y_r[POS_W-1], cam_y_r}) - $signed((POS_W+1)'(cfg.range_y));
    cl_lo_z = $signed({cam_z_r[POS_W-1], cam_z_r}) - $signed((POS_W+1)'(cfg.range_z));
    cl_hi_x = $signed({cam_x_r[POS_W-1], cam_x_r}) + $signed((POS_W+1)'(cfg.range_x));
    cl_hi_y = $signed({cam_y_r[POS_W-1], cam_y_r}) + $signed((POS_W+1)'(cfg.range_y));
    cl_hi_z = $signed({cam_z_r[POS_W-1], cam_z_r}) + $signed((POS_W+1)'(cfg.range_z));
    k_lo_x = clamp_box(pos_idx(cl_lo_x), TOP_X);
    k_lo_y = clamp_box(pos_idx(cl_lo_y), TOP_Y);
    k_lo_z = clamp_box(pos_idx(cl_lo_z), TOP_Z);
    k_hi_x = clamp_box(pos_idx(cl_hi_x), TOP_X);
    k_hi_y = clamp_box(pos_idx(cl_hi_y), TOP_Y);
    k_hi_z = clamp_box(pos_idx(cl_hi_z), TOP_Z);

    d_x = $signed({cmd_r.px[POS_W-1], cmd_r.px}) - $signed({cam_x_r[POS_W-1], cam_x_r});
    d_y = $signed({cmd_r.py[POS_W-1], cmd_r.py}) - $signed({cam_y_r[POS_W-1], cam_y_r});
    d_z = $signed({cmd_r.pz[POS_W-1], cmd_r.pz}) - $signed({cam_z_r[POS_W-1], cam_z_r});
    a_x = (d_x < 0) ? unsigned'(-d_x) : unsigned'(d_x);
    a_y = (d_y < 0) ? unsigned'(-d_y) : unsigned'(d_y);
    a_z = (d_z < 0) ? unsigned'(-d_z) : unsigned'(d_z);
    in_rng = (a_x < (POS_W+1)'(cfg.range_x)) && (a_y < (POS_W+1)'(cfg.range_y)) &&
             (a_z < (POS_W+1)'(cfg.range_z));

    s_eff  = (int'(cfg.inflate) > MAX_INFLATE) ? STEP_W'(MAX_INFLATE) : cfg.inflate;
    s_box  = $signed(BOX_W'(s_eff));
    m_lo_x = c_x_r - s_box;
    m_hi_x = c_x_r + s_box;
    m_lo_y = c_y_r - s_box;
    m_hi_y = c_y_r + s_box;
    m_lo_z = c_z_r - BOX_W'(1);
    m_hi_z = c_z_r + BOX_W'(1);
    m_empty = (m_hi_x < 0) || (m_lo_x > TOP_X) || (m_hi_y < 0) || (m_lo_y > TOP_Y);

    for (int k = 0; k < GRID_Z; k++) begin
      clr_mask[k] = ($signed(BOX_W'(k)) >= k_lo_z) && ($signed(BOX_W'(k)) <= k_hi_z);
      mrk_mask[k] = ($signed(BOX_W'(k)) >= m_lo_z) && ($signed(BOX_W'(k)) <= m_hi_z);
    end

    cv_x   = pos_idx({cam_x_r[POS_W-1], cam_x_r});
    cv_y   = pos_idx({cam_y_r[POS_W-1], cam_y_r});
    cv_z   = pos_idx({cam_z_r[POS_W-1], cam_z_r});
    f_lo_x = clamp_box((blo_x_r < cv_x) ? blo_x_r : cv_x, TOP_X);
    f_lo_y = clamp_box((blo_y_r < cv_y) ? blo_y_r : cv_y, TOP_Y);
    f_lo_z = clamp_box((blo_z_r < cv_z) ? blo_z_r : cv_z, TOP_Z);
    f_hi_x = clamp_box((bhi_x_r > cv_x) ? bhi_x_r : cv_x, TOP_X);
    f_hi_y = clamp_box((bhi_y_r > cv_y) ? bhi_y_r : cv_y, TOP_Y);
    f_hi_z = clamp_box((bhi_z_r > cv_z) ? bhi_z_r : cv_z, TOP_Z);

    col_last = (x_r == xe_r) && (y_r == ye_r);

    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {x_r, y_r};
    mem_raddr = {x_r, y_r};
    mem_wdata = set_r ? (rdata_r | mask_r) : (rdata_r & ~mask_r);
    unique case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_addr_r;
        mem_wdata = '0;
      end
      ST_RD_WAIT: begin
        mem_re    = 1'b1;
        mem_raddr = {XW'(cmd_r.rx), YW'(cmd_r.ry)};
      end
      ST_COL_RD: mem_re = 1'b1;
      ST_COL_WR: mem_we = 1'b1;
      default: ;
    endcase

    res_set = 1'b0;
    res_nxt = '0;
    unique case (state_r)
      ST_RD_OUT: begin
        res_set          = slot_free;
        res_nxt.occupied = cmd_r.rd_in_map && rdata_r[ZW'(cmd_r.rz)];
      end
      ST_NOODOM: begin
        res_set         = slot_free;
        res_nxt.kind    = 1'b1;
        res_nxt.no_odom = 1'b1;
      end
      ST_FIN: begin
        res_set           = slot_free;
        res_nxt.kind      = 1'b1;
        res_nxt.box_min_x = OUT_XW'(f_lo_x);
        res_nxt.box_min_y = OUT_YW'(f_lo_y);
        res_nxt.box_min_z = OUT_ZW'(f_lo_z);
        res_nxt.box_max_x = OUT_XW'(f_hi_x);
        res_nxt.box_max_y = OUT_YW'(f_hi_y);
        res_nxt.box_max_z = OUT_ZW'(f_hi_z);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_addr_r <= '0;
      cam_x_r     <= '0;
      cam_y_r     <= '0;
      cam_z_r     <= '0;
      odom_r      <= 1'b0;
      active_r    <= 1'b0;
      blo_x_r     <= BOX_W'(GRID_X);
      blo_y_r     <= BOX_W'(GRID_Y);
      blo_z_r     <= BOX_W'(GRID_Z);
      bhi_x_r     <= '0;
      bhi_y_r     <= '0;
      bhi_z_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_set) begin
        res_r       <= res_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_INIT: begin
          init_addr_r <= init_addr_r + 1'b1;
          if (&init_addr_r) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            cmd_r <= cmd;
            unique case (cmd.kind)
              CMD_ODOM: begin
                cam_x_r <= cmd.px;
                cam_y_r <= cmd.py;
                cam_z_r <= cmd.pz;
                odom_r  <= 1'b1;
              end
              CMD_READ: state_r <= ST_RD_WAIT;
              CMD_POINT: begin
                if (!odom_r) begin
                  if (cmd.last) begin
                    active_r <= 1'b0;
                    state_r  <= ST_NOODOM;
                  end
                end else if (cmd.first || !active_r) begin
                  state_r <= ST_CLR_SET;
                end else begin
                  state_r <= ST_MCHK;
                end
              end
              default: ;
            endcase
          end
        end
        ST_RD_WAIT: state_r <= ST_RD_OUT;
        ST_RD_OUT: begin
          if (slot_free) begin
            state_r <= ST_IDLE;
          end
        end
        ST_NOODOM: begin
          if (slot_free) begin
            state_r <= ST_IDLE;
          end
        end
        ST_CLR_SET: begin
          active_r <= 1'b1;
          blo_x_r  <= BOX_W'(GRID_X);
          blo_y_r  <= BOX_W'(GRID_Y);
          blo_z_r  <= BOX_W'(GRID_Z);
          bhi_x_r  <= '0;
          bhi_y_r  <= '0;
          bhi_z_r  <= '0;
          x_r      <= XW'(k_lo_x);
          xe_r     <= XW'(k_hi_x);
          y_r      <= YW'(k_lo_y);
          ys_r     <= YW'(k_lo_y);
          ye_r     <= YW'(k_hi_y);
          mask_r   <= clr_mask;
          set_r    <= 1'b0;
          state_r  <= ST_COL_RD;
        end
        ST_MCHK: begin
          c_x_r <= pos_idx({cmd_r.px[POS_W-1], cmd_r.px});
          c_y_r <= pos_idx({cmd_r.py[POS_W-1], cmd_r.py});
          c_z_r <= pos_idx({cmd_r.pz[POS_W-1], cmd_r.pz});
          if (in_rng) begin
            state_r <= ST_MSET;
          end else begin
            state_r <= cmd_r.last ? ST_FIN : ST_IDLE;
          end
        end
        ST_MSET: begin
          if (m_lo_x < blo_x_r) blo_x_r <= m_lo_x;
          if (m_lo_y < blo_y_r) blo_y_r <= m_lo_y;
          if (m_lo_z < blo_z_r) blo_z_r <= m_lo_z;
          if (m_hi_x > bhi_x_r) bhi_x_r <= m_hi_x;
          if (m_hi_y > bhi_y_r) bhi_y_r <= m_hi_y;
          if (m_hi_z > bhi_z_r) bhi_z_r <= m_hi_z;
          x_r    <= XW'(clamp_box(m_lo_x, TOP_X));
          xe_r   <= XW'(clamp_box(m_hi_x, TOP_X));
          y_r    <= YW'(clamp_box(m_lo_y, TOP_Y));
          ys_r   <= YW'(clamp_box(m_lo_y, TOP_Y));
          ye_r   <= YW'(clamp_box(m_hi_y, TOP_Y));
          mask_r <= mrk_mask;
          set_r  <= 1'b1;
          if (m_empty) begin
            state_r <= cmd_r.last ? ST_FIN : ST_IDLE;
          end else begin
            state_r <= ST_COL_RD;
          end
        end
        ST_COL_RD: state_r <= ST_COL_WR;
        ST_COL_WR: begin
          if (y_r == ye_r) begin
            y_r <= ys_r;
            x_r <= x_r + 1'b1;
          end else begin
            y_r <= y_r + 1'b1;
          end
          if (!col_last) begin
            state_r <= ST_COL_RD;
          end else if (!set_r) begin
            state_r <= ST_MCHK;
          end else begin
            state_r <= cmd_r.last ? ST_FIN : ST_IDLE;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            active_r <= 1'b0;
            state_r  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = res_r.kind;
  assign out_ch.occupied  = res_r.occupied;
  assign out_ch.no_odom   = res_r.no_odom;
  assign out_ch.box_min_x = res_r.box_min_x;
  assign out_ch.box_min_y = res_r.box_min_y;
  assign out_ch.box_min_z = res_r.box_min_z;
  assign out_ch.box_max_x = res_r.box_max_x;
  assign out_ch.box_max_y = res_r.box_max_y;
  assign out_ch.box_max_z = res_r.box_max_z;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty) else $error("pop from empty queue");
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COL_WR) |-> ($past(state_r) == ST_COL_RD)) else $error("write without read");
  a_col_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COL_RD) |-> (x_r <= xe_r && y_r <= ye_r)) else $error("column out of window");
  a_no_pop_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> !pop) else $error("command taken during clear pass");

endmodule

### rtl/voxel_occupancy_inflation_top.sv
// ---------------------------------------------------------------------------
// voxel_occupancy_inflation_top
// Inflated 3D occupancy grid with cloud clearing and bounding box report.
// ---------------------------------------------------------------------------
// Odometry beat: taken in the back end's idle state. Voxel read: word read in ST_RD_WAIT,
//   result registered in ST_RD_OUT once the result slot is free. Cloud point: one
//   read/modify/write per x/y column touched by the memory port (one z column per word);
//   first point also runs the clear window. Two-beat command queue in front.
// Reset: synchronous; a clear pass then zeroes the grid, no beats taken.
// ---------------------------------------------------------------------------
module voxel_occupancy_inflation_top (
  input  logic                                clk,
  input  logic                                rst_n,
  voi_in_if.sink                              in_ch,
  voi_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [voi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [voi_pkg::RNG_W-1:0]           cfg_wdata
);
  import voi_pkg::*;

  cfg_t       cfg_r;
  cmd_t       f_cmd, q_cmd;
  logic       push, q_full, q_empty;
  back_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_x <= RNG_W'(10240);
      cfg_r.range_y <= RNG_W'(10240);
      cfg_r.range_z <= RNG_W'(5120);
      cfg_r.inflate <= STEP_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_RANGE_X: cfg_r.range_x <= cfg_wdata;
        CFG_RANGE_Y: cfg_r.range_y <= cfg_wdata;
        CFG_RANGE_Z: cfg_r.range_z <= cfg_wdata;
        CFG_INFLATE: cfg_r.inflate <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  voi_front u_front (
    .in_ch     (in_ch),
    .init_busy (stat.init_busy),
    .q_full    (q_full),
    .push      (push),
    .cmd       (f_cmd)
  );

  voi_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (f_cmd),
    .full  (q_full),
    .pop   (stat.pop),
    .dout  (q_cmd),
    .empty (q_empty)
  );

  voi_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .cmd     (q_cmd),
    .q_empty (q_empty),
    .stat    (stat),
    .out_ch  (out_ch)
  );

endmodule

### verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Checks voxel_occupancy_inflation_top against a behavioral occupancy grid:
// odometry, cloud clearing, inflated marking, bounding boxes and voxel reads,
// under random source gaps and sink stalls and several register settings.
// ---------------------------------------------------------------------------
module testbench;
  import voi_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic       KIND_READ = 1'b0;
  localparam logic       KIND_BOX  = 1'b1;
  localparam longint     ONE_VOX   = longint'(1) << FRAC_BITS;

  typedef struct {
    logic [1:0]              op;
    logic                    first;
    logic                    last;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic [RD_XW-1:0]        rx;
    logic [RD_YW-1:0]        ry;
    logic [RD_ZW-1:0]        rz;
  } beat_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RNG_W-1:0] cfg_wdata;

  voi_in_if  in_ch ();
  voi_out_if out_ch ();

  voxel_occupancy_inflation_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // grid model: one 32-bit z column per (x, y)
  bit [GRID_Z-1:0] grid_col [0:GRID_X*GRID_Y-1];
  longint cam [3];
  longint box_lo [3];
  longint box_hi [3];
  longint half_rng [3];
  int     inflate;
  bit     odom_seen;
  bit     cloud_on;

  beat_t  beat_q [$];
  res_t   expected_q [$];
  bit     sending;
  int     src_gap;
  int     snk_stall;
  bit     src_burst;
  bit     snk_burst;
  bit     failed;
  longint gen_cam [3];

  function automatic longint grid_dim(int a);
    return (a == 0) ? GRID_X : (a == 1) ? GRID_Y : GRID_Z;
  endfunction

  function automatic longint vox(longint p);
    return p >>> FRAC_BITS;
  endfunction

  function automatic longint clamp_ax(longint v, int a);
    if (v < 0) return 0;
    if (v > grid_dim(a) - 1) return grid_dim(a) - 1;
    return v;
  endfunction

  task automatic clear_window();
    longint lo [3];
    longint hi [3];
    bit [GRID_Z-1:0] zmask;
    zmask = '0;
    for (int a = 0; a < 3; a++) begin
      lo[a] = clamp_ax(vox(cam[a] - half_rng[a]), a);
      hi[a] = clamp_ax(vox(cam[a] + half_rng[a]), a);
      box_lo[a] = grid_dim(a);
      box_hi[a] = 0;
    end
    for (longint z = lo[2]; z <= hi[2]; z++) zmask[z] = 1'b1;
    for (longint x = lo[0]; x <= hi[0]; x++)
      for (longint y = lo[1]; y <= hi[1]; y++)
        grid_col[x*GRID_Y + y] &= ~zmask;
    cloud_on = 1'b1;
  endtask

  task automatic mark_inflated(longint p [3]);
    longint c [3];
    longint d;
    longint s;
    s = inflate;
    for (int a = 0; a < 3; a++) begin
      d = p[a] - cam[a];
      if (d < 0) d = -d;
      if (d >= half_rng[a]) return;
      c[a] = vox(p[a]);
    end
    if (c[0] - s < box_lo[0]) box_lo[0] = c[0] - s;
    if (c[1] - s < box_lo[1]) box_lo[1] = c[1] - s;
    if (c[2] - 1 < box_lo[2]) box_lo[2] = c[2] - 1;
    if (c[0] + s > box_hi[0]) box_hi[0] = c[0] + s;
    if (c[1] + s > box_hi[1]) box_hi[1] = c[1] + s;
    if (c[2] + 1 > box_hi[2]) box_hi[2] = c[2] + 1;
    for (longint x = c[0] - s; x <= c[0] + s; x++)
      for (longint y = c[1] - s; y <= c[1] + s; y++)
        if (x >= 0 && x < GRID_X && y >= 0 && y < GRID_Y)
          for (longint z = c[2] - 1; z <= c[2] + 1; z++)
            if (z >= 0 && z < GRID_Z) grid_col[x*GRID_Y + y][z] = 1'b1;
  endtask

  task automatic predict_beat(beat_t b);
    longint p [3];
    longint lo [3];
    longint hi [3];
    longint cv;
    res_t r;
    r = '0;
    p[0] = longint'(b.px);
    p[1] = longint'(b.py);
    p[2] = longint'(b.pz);
    case (b.op)
      OP_ODOM: begin
        cam = p;
        odom_seen = 1'b1;
      end
      OP_READ: begin
        r.kind = KIND_READ;
        r.occupied = grid_col[int'(b.rx)*GRID_Y + int'(b.ry)][b.rz];
        expected_q.insert(expected_q.size(), r);
      end
      OP_POINT: begin
        if (!odom_seen) begin
          if (b.last) begin
            cloud_on = 1'b0;
            r.kind = KIND_BOX;
            r.no_odom = 1'b1;
            expected_q.insert(expected_q.size(), r);
          end
        end else begin
          if (b.first || !cloud_on) clear_window();
          mark_inflated(p);
          if (b.last) begin
            for (int a = 0; a < 3; a++) begin
              cv = vox(cam[a]);
              lo[a] = box_lo[a] < cv ? box_lo[a] : cv;
              hi[a] = box_hi[a] > cv ? box_hi[a] : cv;
            end
            if (hi[2] < 0) hi[2] = 0;
            for (int a = 0; a < 3; a++) begin
              lo[a] = clamp_ax(lo[a], a);
              hi[a] = clamp_ax(hi[a], a);
            end
            cloud_on = 1'b0;
            r.kind = KIND_BOX;
            r.box_min_x = lo[0][OUT_XW-1:0];
            r.box_min_y = lo[1][OUT_YW-1:0];
            r.box_min_z = lo[2][OUT_ZW-1:0];
            r.box_max_x = hi[0][OUT_XW-1:0];
            r.box_max_y = hi[1][OUT_YW-1:0];
            r.box_max_z = hi[2][OUT_ZW-1:0];
            expected_q.insert(expected_q.size(), r);
          end
        end
      end
      default: ;
    endcase
  endtask

  // ---- stimulus builders ----
  function automatic void push_beat(logic [1:0] op, bit f, bit l, longint x, longint y,
                                    longint z, int rx = 0, int ry = 0, int rz = 0);
    beat_t b;
    b.op = op; b.first = f; b.last = l;
    b.px = x[POS_W-1:0]; b.py = y[POS_W-1:0]; b.pz = z[POS_W-1:0];
    b.rx = rx[RD_XW-1:0]; b.ry = ry[RD_YW-1:0]; b.rz = rz[RD_ZW-1:0];
    if (op == OP_ODOM) begin
      gen_cam[0] = longint'(b.px);
      gen_cam[1] = longint'(b.py);
      gen_cam[2] = longint'(b.pz);
    end
    beat_q.insert(beat_q.size(), b);
  endfunction

  function automatic void push_read(longint x, longint y, longint z);
    push_beat(OP_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              longint'($urandom), longint'($urandom), longint'($urandom),
              int'(clamp_ax(x, 0)), int'(clamp_ax(y, 1)), int'(clamp_ax(z, 2)));
  endfunction

  function automatic longint near(int a);
    longint span;
    span = half_rng[a] + ONE_VOX / 2;
    return gen_cam[a] + longint'($urandom_range(0, int'(2*span))) - span;
  endfunction

  function automatic void gen_random(int n);
    int cnt;
    int r;
    int k;
    longint x, y, z;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_beat(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)),
                  longint'($urandom), longint'($urandom), longint'($urandom),
                  $urandom, $urandom, $urandom);
        cnt++;
      end else if (r < 22) begin
        push_beat(OP_ODOM, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  longint'($urandom_range(0, 262*256)) - 3*256,
                  longint'($urandom_range(0, 262*256)) - 3*256,
                  longint'($urandom_range(0, 36*256)) - 2*256);
        cnt++;
      end else if (r < 32) begin
        push_read(longint'($urandom_range(0, 255)), longint'($urandom_range(0, 255)),
                  longint'($urandom_range(0, 31)));
        cnt++;
      end else begin
        k = $urandom_range(1, 8);
        for (int i = 0; i < k; i++) begin
          x = near(0); y = near(1); z = near(2);
          push_beat(OP_POINT, (i == 0) && ($urandom_range(0, 9) != 0),
                    (i == k-1) && ($urandom_range(0, 9) != 0), x, y, z);
          cnt++;
          if ($urandom_range(0, 2) == 0) begin
            push_read(vox(x) + longint'($urandom_range(0, 4)) - 2,
                      vox(y) + longint'($urandom_range(0, 4)) - 2,
                      vox(z) + longint'($urandom_range(0, 2)) - 1);
            cnt++;
          end
        end
      end
    end
  endfunction

  task automatic wait_idle();
    wait (beat_q.size() == 0 && !sending && expected_q.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic finish_phase();
    push_read(longint'($urandom_range(0, 255)), longint'($urandom_range(0, 255)),
              longint'($urandom_range(0, 31)));
    wait_idle();
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [RNG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      CFG_RANGE_X: half_rng[0] = val;
      CFG_RANGE_Y: half_rng[1] = val;
      CFG_RANGE_Z: half_rng[2] = val;
      CFG_INFLATE: inflate = (val[STEP_W-1:0] > MAX_INFLATE) ? MAX_INFLATE
                                                             : val[STEP_W-1:0];
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(int rx, int ry, int rz, int inf);
    write_reg(CFG_RANGE_X, RNG_W'(rx));
    write_reg(CFG_RANGE_Y, RNG_W'(ry));
    write_reg(CFG_RANGE_Z, RNG_W'(rz));
    write_reg(CFG_INFLATE, RNG_W'(inf));
  endtask

  // ---- clock, reset, limit ----
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("voxel_occupancy_inflation_top test failed");
    $finish;
  end

  // ---- source driver ----
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_beat(beat_q[0]);
      beat_q.pop_front();
      sending <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst_n && !(sending && in_ch.valid)) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (beat_q.size() > 0) begin
        in_ch.op <= beat_q[0].op;
        in_ch.first_point <= beat_q[0].first;
        in_ch.last_point <= beat_q[0].last;
        in_ch.pos_x <= beat_q[0].px;
        in_ch.pos_y <= beat_q[0].py;
        in_ch.pos_z <= beat_q[0].pz;
        in_ch.read_x <= beat_q[0].rx;
        in_ch.read_y <= beat_q[0].ry;
        in_ch.read_z <= beat_q[0].rz;
        in_ch.valid <= 1'b1;
        sending <= 1'b1;
        if ($urandom_range(0, 49) == 0) src_burst = ~src_burst;
        src_gap <= src_burst ? 0 : $urandom_range(0, 19);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---- sink monitor ----
  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result beat with no expectation pending");
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        check_field("kind", e.kind, out_ch.kind);
        check_field("occupied", e.occupied, out_ch.occupied);
        check_field("no_odom", e.no_odom, out_ch.no_odom);
        check_field("box_min_x", e.box_min_x, out_ch.box_min_x);
        check_field("box_min_y", e.box_min_y, out_ch.box_min_y);
        check_field("box_min_z", e.box_min_z, out_ch.box_min_z);
        check_field("box_max_x", e.box_max_x, out_ch.box_max_x);
        check_field("box_max_y", e.box_max_y, out_ch.box_max_y);
        check_field("box_max_z", e.box_max_z, out_ch.box_max_z);
      end
      if ($urandom_range(0, 29) == 0) snk_burst = ~snk_burst;
      snk_stall <= snk_burst ? 0 : $urandom_range(0, 19);
    end
  end

  always @(negedge clk) begin
    if (snk_stall > 0) begin
      snk_stall <= snk_stall - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n;
    end
  end

  // ---- sequence ----
  initial begin
    in_ch.valid = 1'b0; in_ch.op = OP_ODOM; in_ch.first_point = 1'b0;
    in_ch.last_point = 1'b0; in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.read_x = '0; in_ch.read_y = '0; in_ch.read_z = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0; cfg_index = CFG_RANGE_X; cfg_wdata = '0;
    sending = 1'b0; src_gap = 0; snk_stall = 0; src_burst = 1'b0; snk_burst = 1'b0;
    failed = 1'b0;
    foreach (grid_col[i]) grid_col[i] = '0;
    for (int a = 0; a < 3; a++) begin
      cam[a] = 0; gen_cam[a] = 0; box_lo[a] = grid_dim(a); box_hi[a] = 0;
    end
    half_rng[0] = 10240; half_rng[1] = 10240; half_rng[2] = 5120;
    inflate = 1; odom_seen = 1'b0; cloud_on = 1'b0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: no odometry yet, unused op, then small clouds
    push_read(0, 0, 0);
    push_beat(OP_POINT, 1, 0, 100, 100, 100);
    push_beat(OP_POINT, 0, 1, 200, 200, 200);
    push_beat(OP_UNUSED, 1, 1, -1, -1, -1, 255, 255, 31);
    push_beat(OP_ODOM, 0, 0, 10*256 + 128, 10*256 + 128, 5*256);
    push_beat(OP_POINT, 1, 1, 12*256, 11*256, 6*256);
    push_read(12, 11, 6);
    push_read(13, 12, 7);
    push_beat(OP_POINT, 0, 0, 1*256, 2*256, 0);
    push_beat(OP_POINT, 0, 0, -128, -300, -100);
    push_beat(OP_POINT, 0, 0, 8388607, 8388607, 8388607);
    push_beat(OP_POINT, 0, 1, -8388608, -8388608, -8388608);
    push_read(0, 0, 0);
    push_read(1, 2, 1);
    push_beat(OP_ODOM, 0, 0, 255*256 + 200, 255*256 + 200, 31*256 + 200);
    push_beat(OP_POINT, 1, 0, 255*256 + 10, 250*256, 31*256);
    push_beat(OP_POINT, 0, 1, 255*256 + 200, 255*256 + 200, 30*256);
    push_read(255, 255, 31);
    push_read(254, 249, 30);
    push_beat(OP_ODOM, 0, 0, -8388608, 8388607, -8388608);
    push_beat(OP_POINT, 1, 1, -8388608, 8388607, -8388608);
    push_read(255, 0, 31);
    finish_phase();

    set_config(0, 0, 0, 0);
    push_beat(OP_ODOM, 0, 0, 40*256, 40*256, 4*256);
    push_beat(OP_POINT, 1, 1, 40*256, 40*256, 4*256);
    gen_random(25);
    finish_phase();

    set_config(65535, 65535, 65535, 7);
    push_beat(OP_ODOM, 0, 0, 128*256, 128*256, 16*256);
    push_beat(OP_POINT, 1, 0, 3*256, 250*256, 1*256);
    push_beat(OP_POINT, 0, 0, 128*256, 128*256, 31*256);
    push_beat(OP_POINT, 0, 1, 250*256, 4*256, 0);
    push_read(10, 247, 2);
    push_read(128, 128, 31);
    push_read(255, 0, 0);
    finish_phase();

    for (int ph = 0; ph < 14; ph++) begin
      set_config($urandom_range(0, 3072), $urandom_range(0, 3072),
                 $urandom_range(0, 2048), $urandom_range(0, 7));
      gen_random(55);
      finish_phase();
    end

    if (!failed) begin
      $display("voxel_occupancy_inflation_top test passed");
    end else begin
      $display("voxel_occupancy_inflation_top test failed");
    end
    $finish;
  end

endmodule
